// ----- rtl/ggef_pkg.sv -----
// Shared types and constants of the glyph grid extent finder.
`default_nettype none
package ggef_pkg;

  localparam int unsigned MAX_CELL_SIZE = 64;
  localparam int unsigned GRID_CELLS    = 16;
  localparam int unsigned GLYPH_COUNT   = 256;

  localparam int unsigned CELL_POS_W  = $clog2(MAX_CELL_SIZE);
  localparam int unsigned CELL_SIZE_W = CELL_POS_W + 1;
  localparam int unsigned GRID_W      = $clog2(GRID_CELLS);
  localparam int unsigned GLYPH_W     = $clog2(GLYPH_COUNT);

  localparam logic [GLYPH_W-1:0]     LETTER_A_IDX  = GLYPH_W'(65);
  localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RST = CELL_SIZE_W'(8);
  localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_MAX = CELL_SIZE_W'(MAX_CELL_SIZE);

  typedef enum logic {
    CFG_CELL_WIDTH  = 1'b0,
    CFG_CELL_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic                  vld;
    logic [CELL_POS_W-1:0] left;
    logic [CELL_POS_W-1:0] right;
  } extent_t;

  // Clamp a programmed size into 1..MAX_CELL_SIZE.
  function automatic logic [CELL_SIZE_W-1:0] eff_size(input logic [CELL_SIZE_W-1:0] v);
    logic [CELL_SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CELL_SIZE_W'(1);
    end else if (v > CELL_SIZE_MAX) begin
      r = CELL_SIZE_MAX;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/glyph_grid_extent_finder.sv -----
// Top level of the glyph grid extent finder: scan bookkeeping, extent memory and query path.
`default_nettype none
// Font sheet scanner. Pixels of a 16 x 16 grid of glyph cells arrive in raster order; a
// transfer with frame_start marks pixel (0,0) and sets the background color. For each cell
// the leftmost and rightmost ink columns live in a 256 x 13 extent memory (one entry per
// cell); the common top ink row and the last ink row of cell 'A' sit in registers. A query
// transfer returns the trimmed rectangle of one cell plus space width and line height.
// Each item is handled in order: first the cell's entry is read from the synchronous memory,
// then the pixel is merged and the entry written back (or the result is built). The block
// takes no new item until the current one is done; a query additionally waits while an
// earlier result is still held on a stalled output. Extent entries are not cleared after
// reset; an entry is cleared when the first pixel of its cell is scanned, so only query
// cells already reached by the scan since reset. cell_width and cell_height are clamped to
// 1..64 and may be written only while the block is idle.
module glyph_grid_extent_finder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [ggef_pkg::CELL_SIZE_W-1:0] cfg_data,
  // input channel
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic                        in_op,
  input  wire logic                        in_frame_start,
  input  wire logic [31:0]                 in_pixel_value,
  input  wire logic [7:0]                  in_glyph_index,
  // result channel
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [9:0]                  out_glyph_x,
  output      logic [10:0]                 out_glyph_y,
  output      logic [6:0]                  out_glyph_w,
  output      logic [6:0]                  out_glyph_h,
  output      logic [5:0]                  out_space_width,
  output      logic [6:0]                  out_line_height
);
  import ggef_pkg::*;

  // configuration registers
  logic [CELL_SIZE_W-1:0] cell_width_r;
  logic [CELL_SIZE_W-1:0] cell_height_r;
  logic [CELL_SIZE_W-1:0] cw;
  logic [CELL_SIZE_W-1:0] ch;

  // scan state
  state_t                 state_r, state_nxt;
  logic [31:0]            bg_r, bg_nxt;
  logic [CELL_POS_W-1:0]  icc_r, icc_nxt;
  logic [GRID_W-1:0]      cc_r, cc_nxt;
  logic [CELL_POS_W-1:0]  icr_r, icr_nxt;
  logic [GRID_W-1:0]      cr_r, cr_nxt;
  logic [CELL_SIZE_W-1:0] top_row_r, top_row_nxt;
  logic [CELL_SIZE_W-1:0] a_bot_r, a_bot_nxt;

  // held item
  logic                   item_op_r;
  logic                   item_fs_r;
  logic [31:0]            item_pix_r;
  logic [GLYPH_W-1:0]     item_gi_r;

  // extent memory
  extent_t                mem [GLYPH_COUNT];
  extent_t                rd_data_r;
  logic [GLYPH_W-1:0]     rd_addr;
  logic                   rd_en;
  logic                   wr_en;
  logic [GLYPH_W-1:0]     wr_addr;
  extent_t                wr_data;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [9:0]             out_x_r, out_x_nxt;
  logic [10:0]            out_y_r, out_y_nxt;
  logic [6:0]             out_w_r, out_w_nxt;
  logic [6:0]             out_h_r, out_h_nxt;
  logic [5:0]             out_sp_r, out_sp_nxt;
  logic [6:0]             out_lh_r, out_lh_nxt;

  logic                   in_xfer;
  logic                   exec_fire;
  logic                   pix_fire;
  logic                   qry_fire;

  // effective scan values after a possible frame restart
  logic [31:0]            e_bg;
  logic [CELL_POS_W-1:0]  e_icc;
  logic [GRID_W-1:0]      e_cc;
  logic [CELL_POS_W-1:0]  e_icr;
  logic [GRID_W-1:0]      e_cr;
  logic [CELL_SIZE_W-1:0] e_top;
  logic [CELL_SIZE_W-1:0] e_abot;
  logic                   ink;
  extent_t                cur;
  logic [CELL_SIZE_W-1:0] icc_inc;
  logic [CELL_SIZE_W-1:0] icr_inc;

  assign cw = eff_size(cell_width_r);
  assign ch = eff_size(cell_height_r);

  assign in_xfer   = in_valid && !in_stall;
  // a query may only finish when the result register is free or being drained
  assign exec_fire = (state_r == ST_EXEC) &&
                     ((item_op_r == OP_PIXEL) || !(out_valid_r && out_stall));
  assign pix_fire  = exec_fire && (item_op_r == OP_PIXEL);
  assign qry_fire  = exec_fire && (item_op_r == OP_QUERY);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_EXEC: in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  // Read address: a frame start restarts the scan at cell (0,0).
  assign rd_en   = in_xfer;
  assign rd_addr = (in_op == OP_QUERY) ? in_glyph_index :
                   (in_frame_start ? '0 : {cr_r, cc_r});

  // Merge one pixel into the cell entry and advance the raster counters.
  always_comb begin
    e_bg   = item_fs_r ? item_pix_r : bg_r;
    e_icc  = item_fs_r ? '0 : icc_r;
    e_cc   = item_fs_r ? '0 : cc_r;
    e_icr  = item_fs_r ? '0 : icr_r;
    e_cr   = item_fs_r ? '0 : cr_r;
    e_top  = item_fs_r ? ch : top_row_r;
    e_abot = item_fs_r ? ch : a_bot_r;

    ink = (item_pix_r != e_bg);
    cur = rd_data_r;
    // first pixel of a cell: drop whatever the entry held
    if (e_icc == '0 && e_icr == '0) cur = '0;

    wr_data     = cur;
    top_row_nxt = e_top;
    a_bot_nxt   = e_abot;
    if (ink) begin
      if (!cur.vld) begin
        wr_data.vld   = 1'b1;
        wr_data.left  = e_icc;
        wr_data.right = e_icc;
      end else begin
        if (e_icc < cur.left)  wr_data.left  = e_icc;
        if (e_icc > cur.right) wr_data.right = e_icc;
      end
      if (CELL_SIZE_W'(e_icr) < e_top) top_row_nxt = CELL_SIZE_W'(e_icr);
      if ({e_cr, e_cc} == LETTER_A_IDX) a_bot_nxt = CELL_SIZE_W'(e_icr);
    end
    wr_addr = {e_cr, e_cc};
    wr_en   = pix_fire;

    icc_inc = CELL_SIZE_W'(e_icc) + CELL_SIZE_W'(1);
    icr_inc = CELL_SIZE_W'(e_icr) + CELL_SIZE_W'(1);
    icc_nxt = e_icc + CELL_POS_W'(1);
    cc_nxt  = e_cc;
    icr_nxt = e_icr;
    cr_nxt  = e_cr;
    if (icc_inc >= cw) begin
      icc_nxt = '0;
      cc_nxt  = e_cc + GRID_W'(1);
      if (e_cc == {GRID_W{1'b1}}) begin
        icr_nxt = e_icr + CELL_POS_W'(1);
        if (icr_inc >= ch) begin
          icr_nxt = '0;
          cr_nxt  = e_cr + GRID_W'(1);
        end
      end
    end
    bg_nxt = e_bg;
  end

  // Build the query result.
  always_comb begin
    logic [10:0] x_full;
    logic [10:0] y_full;
    x_full = 11'(item_gi_r[GRID_W-1:0]) * 11'(cw);
    out_w_nxt = cw;
    if (rd_data_r.vld) begin
      x_full    = x_full + 11'(rd_data_r.left);
      out_w_nxt = 7'(rd_data_r.right) - 7'(rd_data_r.left) + 7'd1;
    end
    y_full     = 11'(item_gi_r[GLYPH_W-1:GRID_W]) * 11'(ch) + 11'(top_row_r);
    out_x_nxt  = x_full[9:0];
    out_y_nxt  = y_full;
    out_h_nxt  = (ch > top_row_r) ? 7'(ch - top_row_r) : 7'd0;
    out_lh_nxt = (a_bot_r > top_row_r) ? 7'(a_bot_r - top_row_r) : 7'd0;
    out_sp_nxt = 6'(cw >> 1);

    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (qry_fire) out_valid_nxt = 1'b1;
  end

  // extent memory: read on item transfer, write back on pixel merge
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // control and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cell_width_r  <= CELL_SIZE_RST;
      cell_height_r <= CELL_SIZE_RST;
      bg_r          <= '0;
      icc_r         <= '0;
      cc_r          <= '0;
      icr_r         <= '0;
      cr_r          <= '0;
      top_row_r     <= CELL_SIZE_RST;
      a_bot_r       <= CELL_SIZE_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CELL_WIDTH:  cell_width_r  <= cfg_data;
          CFG_CELL_HEIGHT: cell_height_r <= cfg_data;
          default: ;
        endcase
      end
      if (pix_fire) begin
        bg_r      <= bg_nxt;
        icc_r     <= icc_nxt;
        cc_r      <= cc_nxt;
        icr_r     <= icr_nxt;
        cr_r      <= cr_nxt;
        top_row_r <= top_row_nxt;
        a_bot_r   <= a_bot_nxt;
      end
    end
  end

  // held item and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_op_r  <= in_op;
      item_fs_r  <= in_frame_start;
      item_pix_r <= in_pixel_value;
      item_gi_r  <= in_glyph_index;
    end
    if (qry_fire) begin
      out_x_r  <= out_x_nxt;
      out_y_r  <= out_y_nxt;
      out_w_r  <= out_w_nxt;
      out_h_r  <= out_h_nxt;
      out_sp_r <= out_sp_nxt;
      out_lh_r <= out_lh_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_glyph_x     = out_x_r;
  assign out_glyph_y     = out_y_r;
  assign out_glyph_w     = out_w_r;
  assign out_glyph_h     = out_h_r;
  assign out_space_width = out_sp_r;
  assign out_line_height = out_lh_r;

`ifndef SYNTHESIS
  a_xfer_to_exec : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_EXEC))
    else $error("accepted item did not enter execution");

  a_pixel_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    (pix_fire && !out_valid_r) |=> !out_valid_r)
    else $error("pixel transfer produced a result");

  a_query_result : assert property (@(posedge clk) disable iff (!rst_n)
    qry_fire |=> out_valid_r)
    else $error("query did not produce a result");

  a_top_row_range : assert property (@(posedge clk) disable iff (!rst_n)
    (top_row_r <= CELL_SIZE_MAX) && (a_bot_r <= CELL_SIZE_MAX))
    else $error("tracked row beyond largest cell size");
`endif

endmodule
`default_nettype wire

// ----- test/glyph_grid_extent_finder_tb.sv -----
// Self-checking testbench for the glyph grid extent finder: sheet scans, queries, cell sizes.
`timescale 1ns / 1ps

module glyph_grid_extent_finder_tb;
  import ggef_pkg::*;

  // Two copies of the scan state: the plan copy runs ahead while items are queued, so queries
  // only name cells whose entry has been cleared since reset; the live copy advances on each
  // accepted transfer and produces the expected glyph boxes.
  localparam int VIEW_PLAN   = 0;
  localparam int VIEW_LIVE   = 1;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    op_t         op;
    logic        frame_start;
    logic [31:0] pixel;
    logic [7:0]  glyph;
  } sheet_xfer_t;

  typedef struct packed {
    logic [9:0]  x;
    logic [10:0] y;
    logic [6:0]  w;
    logic [6:0]  h;
    logic [5:0]  space_w;
    logic [6:0]  line_h;
  } glyph_box_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = CFG_CELL_WIDTH;
  logic [CELL_SIZE_W-1:0] cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_op = OP_PIXEL;
  logic                   in_frame_start = 1'b0;
  logic [31:0]            in_pixel_value = '0;
  logic [7:0]             in_glyph_index = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [9:0]             out_glyph_x;
  logic [10:0]            out_glyph_y;
  logic [6:0]             out_glyph_w;
  logic [6:0]             out_glyph_h;
  logic [5:0]             out_space_width;
  logic [6:0]             out_line_height;

  glyph_grid_extent_finder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_frame_start  (in_frame_start),
    .in_pixel_value  (in_pixel_value),
    .in_glyph_index  (in_glyph_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_glyph_x     (out_glyph_x),
    .out_glyph_y     (out_glyph_y),
    .out_glyph_w     (out_glyph_w),
    .out_glyph_h     (out_glyph_h),
    .out_space_width (out_space_width),
    .out_line_height (out_line_height)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Programmed cell sizes, raw as written; both scan copies clamp them on use.
  int unsigned cell_w_reg = 8;
  int unsigned cell_h_reg = 8;

  // Scan state, one slot per copy.
  logic [31:0] bg_color      [2];
  int unsigned col_in_cell   [2];
  int unsigned cell_col      [2];
  int unsigned row_in_cell   [2];
  int unsigned cell_row      [2];
  int unsigned top_ink_row   [2];
  int unsigned a_last_ink_row[2];
  logic [5:0]  ink_left      [2][GLYPH_COUNT];
  logic [5:0]  ink_right     [2][GLYPH_COUNT];
  bit          has_ink       [2][GLYPH_COUNT];
  bit          entry_cleared [2][GLYPH_COUNT];

  sheet_xfer_t sheet_xfers[$];     // transfers waiting for the driver
  glyph_box_t  expected_boxes[$];  // glyph boxes the block still owes
  sheet_xfer_t held_xfer;
  glyph_box_t  live_box;
  glyph_box_t  want_box;
  glyph_box_t  got_box;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;

  function automatic int unsigned clamp_cell(input int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_CELL_SIZE) return MAX_CELL_SIZE;
    return v;
  endfunction

  function automatic void clear_view(input int v);
    bg_color[v]       = '0;
    col_in_cell[v]    = 0;
    cell_col[v]       = 0;
    row_in_cell[v]    = 0;
    cell_row[v]       = 0;
    top_ink_row[v]    = clamp_cell(cell_h_reg);
    a_last_ink_row[v] = clamp_cell(cell_h_reg);
    for (int c = 0; c < GLYPH_COUNT; c++) begin
      ink_left[v][c]      = '0;
      ink_right[v][c]     = '0;
      has_ink[v][c]       = 1'b0;
      entry_cleared[v][c] = 1'b0;
    end
  endfunction

  // Advance one copy of the scan by one transfer. Returns 1 with the glyph box for a query,
  // 0 for a pixel, which updates the scan counters, the cell entry and the shared ink rows.
  function automatic bit scan_sheet(input int v, input sheet_xfer_t t, output glyph_box_t box);
    int unsigned cw;
    int unsigned ch;
    int unsigned idx;
    int unsigned x;
    int unsigned y;
    int unsigned w;
    int unsigned h;
    int unsigned lh;
    int unsigned sw;
    logic [5:0]  col6;
    cw  = clamp_cell(cell_w_reg);
    ch  = clamp_cell(cell_h_reg);
    box = '0;
    if (t.op == OP_QUERY) begin
      idx = 32'(t.glyph);
      x   = (idx % GRID_CELLS) * cw;
      y   = (idx / GRID_CELLS) * ch + top_ink_row[v];
      w   = cw;
      h   = (ch > top_ink_row[v]) ? ch - top_ink_row[v] : 0;
      lh  = (a_last_ink_row[v] > top_ink_row[v]) ? a_last_ink_row[v] - top_ink_row[v] : 0;
      sw  = cw / 2;
      // An empty cell keeps its origin and the full cell width.
      if (has_ink[v][idx]) begin
        x = x + 32'(ink_left[v][idx]);
        w = 32'(ink_right[v][idx]) - 32'(ink_left[v][idx]) + 1;
      end
      box.x       = x[9:0];
      box.y       = y[10:0];
      box.w       = w[6:0];
      box.h       = h[6:0];
      box.space_w = sw[5:0];
      box.line_h  = lh[6:0];
      return 1'b1;
    end
    // Frame start takes the pixel as background and rescans from (0,0).
    if (t.frame_start) begin
      bg_color[v]       = t.pixel;
      col_in_cell[v]    = 0;
      cell_col[v]       = 0;
      row_in_cell[v]    = 0;
      cell_row[v]       = 0;
      top_ink_row[v]    = ch;
      a_last_ink_row[v] = ch;
    end
    idx  = cell_row[v] * GRID_CELLS + cell_col[v];
    col6 = 6'(col_in_cell[v]);
    // Drop the old entry on the first pixel of a cell.
    if (col_in_cell[v] == 0 && row_in_cell[v] == 0) begin
      ink_left[v][idx]      = '0;
      ink_right[v][idx]     = '0;
      has_ink[v][idx]       = 1'b0;
      entry_cleared[v][idx] = 1'b1;
    end
    if (t.pixel != bg_color[v]) begin
      if (!has_ink[v][idx]) begin
        ink_left[v][idx]  = col6;
        ink_right[v][idx] = col6;
        has_ink[v][idx]   = 1'b1;
      end else begin
        if (col6 < ink_left[v][idx]) ink_left[v][idx] = col6;
        if (col6 > ink_right[v][idx]) ink_right[v][idx] = col6;
      end
      if (row_in_cell[v] < top_ink_row[v]) top_ink_row[v] = row_in_cell[v];
      if (idx == 32'(LETTER_A_IDX)) a_last_ink_row[v] = row_in_cell[v];
    end
    // Counters beyond a shrunk size wrap on this advance; the sheet end wraps to cell (0,0).
    col_in_cell[v]++;
    if (col_in_cell[v] >= cw) begin
      col_in_cell[v] = 0;
      cell_col[v]++;
      if (cell_col[v] >= GRID_CELLS) begin
        cell_col[v] = 0;
        row_in_cell[v]++;
        if (row_in_cell[v] >= ch) begin
          row_in_cell[v] = 0;
          cell_row[v]    = (cell_row[v] + 1) % GRID_CELLS;
        end
      end
    end
    return 1'b0;
  endfunction

  // Mostly back to back, some short gaps, a few long ones; none at all in a calm stretch.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: hold the payload while stalled, otherwise idle for the chosen gap and then take
  // the next transfer. The live copy of the scan advances on every accepted transfer.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (scan_sheet(VIEW_LIVE, held_xfer, live_box)) expected_boxes.push_back(live_box);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sheet_xfers.size() != 0) begin
          held_xfer = sheet_xfers.pop_front();
          in_valid       <= 1'b1;
          in_op          <= held_xfer.op;
          in_frame_start <= held_xfer.frame_start;
          in_pixel_value <= held_xfer.pixel;
          in_glyph_index <= held_xfer.glyph;
          send_gap = pick_gap(send_calm);
          if ($urandom_range(0, 79) == 0) send_calm = !send_calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest expected box, field by field,
  // and stall the result channel in runs of random length.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_box = {out_glyph_x, out_glyph_y, out_glyph_w, out_glyph_h, out_space_width,
                   out_line_height};
        if (expected_boxes.size() == 0) begin
          report_mismatch($sformatf("result x=%0d y=%0d w=%0d h=%0d with nothing expected",
                                    got_box.x, got_box.y, got_box.w, got_box.h));
        end else begin
          want_box = expected_boxes.pop_front();
          if (got_box.x !== want_box.x)
            report_mismatch($sformatf("glyph_x %0d, want %0d", got_box.x, want_box.x));
          if (got_box.y !== want_box.y)
            report_mismatch($sformatf("glyph_y %0d, want %0d", got_box.y, want_box.y));
          if (got_box.w !== want_box.w)
            report_mismatch($sformatf("glyph_w %0d, want %0d", got_box.w, want_box.w));
          if (got_box.h !== want_box.h)
            report_mismatch($sformatf("glyph_h %0d, want %0d", got_box.h, want_box.h));
          if (got_box.space_w !== want_box.space_w)
            report_mismatch($sformatf("space_width %0d, want %0d", got_box.space_w,
                                      want_box.space_w));
          if (got_box.line_h !== want_box.line_h)
            report_mismatch($sformatf("line_height %0d, want %0d", got_box.line_h,
                                      want_box.line_h));
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(recv_calm);
        if ($urandom_range(0, 79) == 0) recv_calm = !recv_calm;
      end
    end
  end

  // Watchdog: end the run when no transfer moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers. Every queued transfer also advances the plan copy of the scan.
  // ---------------------------------------------------------------------------------------
  task automatic queue_xfer(input sheet_xfer_t t);
    glyph_box_t scratch;
    void'(scan_sheet(VIEW_PLAN, t, scratch));
    sheet_xfers.push_back(t);
  endtask

  // Pixel transfer; the unused glyph index carries noise.
  task automatic queue_pixel(input logic fs, input logic [31:0] pix);
    sheet_xfer_t t;
    t.op          = OP_PIXEL;
    t.frame_start = fs;
    t.pixel       = pix;
    t.glyph       = 8'($urandom_range(0, 255));
    queue_xfer(t);
  endtask

  // Query transfer; frame start and pixel value are ignored, so fill them with noise.
  task automatic queue_query(input logic [7:0] gi);
    sheet_xfer_t t;
    t.op          = OP_QUERY;
    t.frame_start = 1'($urandom_range(0, 1));
    t.pixel       = $urandom;
    t.glyph       = gi;
    queue_xfer(t);
  endtask

  // Pick a cell whose entry the scan has already cleared; others hold undefined data.
  function automatic logic [7:0] pick_cleared_cell();
    int unsigned start;
    logic [7:0]  gi;
    start = $urandom_range(0, GLYPH_COUNT - 1);
    for (int k = 0; k < GLYPH_COUNT; k++) begin
      gi = 8'((start + k) % GLYPH_COUNT);
      if (entry_cleared[VIEW_PLAN][gi]) return gi;
    end
    return '0;
  endfunction

  // Mostly background, some single-bit near misses, the rest random ink.
  function automatic logic [31:0] paint_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return bg_color[VIEW_PLAN];
    if (r == 6) return bg_color[VIEW_PLAN] ^ (32'h1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  // Raster pixels with queries mixed in; noisy sheets get a stray frame start now and then.
  task automatic queue_sheet(input int unsigned npix, input bit restart, input bit noisy);
    for (int i = 0; i < npix; i++) begin
      if (entry_cleared[VIEW_PLAN][0] && $urandom_range(0, 6) == 0)
        queue_query(pick_cleared_cell());
      if ((i == 0 && restart) || (noisy && $urandom_range(0, 39) == 0))
        queue_pixel(1'b1, $urandom);
      else
        queue_pixel(1'b0, paint_pixel());
    end
  endtask

  // Wait until every transfer went out and every result came back, then let the block
  // finish a trailing pixel with some margin.
  task automatic await_idle();
    while (sheet_xfers.size() != 0 || in_valid || expected_boxes.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write both cell sizes; only called while the block is idle.
  task automatic write_cell_size(input logic [CELL_SIZE_W-1:0] w,
                                 input logic [CELL_SIZE_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CELL_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_CELL_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    cell_w_reg = 32'(w);
    cell_h_reg = 32'(h);
    @(negedge clk);
  endtask

  initial begin
    clear_view(VIEW_PLAN);
    clear_view(VIEW_LIVE);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset size of 8 x 8: all-ones background, ink that differs in a
    // single bit, an empty neighbor cell, a frame restart that clears cell 0 and drops the
    // common top row back to the cell height, and queries mid-scan.
    queue_pixel(1'b1, 32'hFFFF_FFFF);
    queue_pixel(1'b0, 32'h0000_0000);
    queue_pixel(1'b0, 32'hFFFF_FFFE);
    queue_pixel(1'b0, 32'hFFFF_FFFF);
    queue_query(8'd0);
    queue_pixel(1'b0, 32'hFFFF_FFFF);
    queue_pixel(1'b0, 32'hFFFF_FFFF);
    queue_pixel(1'b0, 32'hFFFF_FFFF);
    queue_pixel(1'b0, 32'h7FFF_FFFF);
    queue_pixel(1'b0, 32'hFFFF_FFFF);
    queue_query(8'd1);
    queue_query(8'd0);
    queue_pixel(1'b1, 32'h0000_0000);
    queue_query(8'd0);
    queue_pixel(1'b0, 32'h0000_0005);
    queue_query(8'd0);
    queue_query(8'd1);
    await_idle();

    // One-pixel cells: a whole sheet reaches every cell including 'A' and the last one.
    // Pause halfway until the block has drained, then run past the sheet end so the
    // counters wrap without a frame start.
    write_cell_size(7'd1, 7'd1);
    queue_sheet(140, 1'b1, 1'b0);
    await_idle();
    queue_sheet(120, 1'b0, 1'b0);
    queue_query(8'd0);
    queue_query(LETTER_A_IDX);
    queue_query(8'd255);
    await_idle();

    // Out-of-range sizes: width above the maximum clamps to 64, height 0 clamps to 1.
    write_cell_size(7'd127, 7'd0);
    queue_sheet(70, 1'b1, 1'b0);
    await_idle();

    // Narrowest cells at the tallest height.
    write_cell_size(7'd0, 7'd64);
    queue_sheet(50, 1'b1, 1'b0);
    await_idle();

    // Shrink the size mid-scan: counters beyond the new size wrap on the next advance.
    write_cell_size(7'd3, 7'd2);
    queue_sheet(40, 1'b0, 1'b0);
    await_idle();

    // Small random sizes with stray frame starts breaking the scan.
    write_cell_size(7'($urandom_range(1, 5)), 7'($urandom_range(1, 5)));
    queue_sheet(50, 1'b1, 1'b1);
    await_idle();

    // Both sizes at the maximum.
    write_cell_size(7'd64, 7'd64);
    queue_sheet(30, 1'b1, 1'b0);
    await_idle();

    repeat (16) @(negedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ggef_pkg.sv
rtl/glyph_grid_extent_finder.sv
test/glyph_grid_extent_finder_tb.sv
